@@ hdl/pfb_pkg.sv @@
`default_nettype none

package pfb_pkg;

    // Fixed field widths
    localparam int PERIOD_W   = 24;
    localparam int COUNT_W    = 16;
    localparam int SPEED_W    = 16;
    localparam int TIME_W     = 16;
    localparam int POS_INT_W  = 40;
    localparam int ACTION_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int MUL_A_W    = 24;
    localparam int MUL_B_W    = 17;
    localparam int MUL_P_W    = MUL_A_W + 1 + MUL_B_W;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_TICK = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SEEK = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_STEP = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_ENABLE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_START   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_END     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PAUSED       = 3'd6;

    // Reset values
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 24'd33333;
    localparam logic [COUNT_W-1:0]  COUNT_RST  = 16'd1;
    localparam logic [SPEED_W-1:0]  SPEED_RST  = 16'd256;

    // Effective configuration as seen by the datapath
    typedef struct packed {
        logic [PERIOD_W-1:0]       period;      // zero read as one
        logic [COUNT_W-1:0]        count;       // zero read as one
        logic [COUNT_W-1:0]        last_frame;  // count - 1
        logic                      loop_en;
        logic [COUNT_W-1:0]        loop_start;  // clamped to last_frame
        logic [COUNT_W-1:0]        loop_end;    // clamped to last_frame
        logic signed [SPEED_W-1:0] speed;
        logic                      paused;
    } cfg_t;

endpackage

`default_nettype wire

@@ hdl/playback_frame_timebase.sv @@
`default_nettype none

// Channel   Signals                                      Direction  Moves
// -------   -------------------------------------------  ---------  ---------------------------
// in        in_valid/in_ready, action, elapsed_time,     sink       one command per transaction
//           target_frame, step_frames
// out       out_valid/out_ready, frame_index,            source     one result per transaction
//           play_position
// cfg       cfg_valid/cfg_ready, cfg_index, cfg_data     sink       one register write
//
// A tick uses the shared divider, one bit per cycle, first for the wrap modulo and then
// for the frame index; a looped tick also multiplies out the loop length first. A tick
// on an empty loop window, a paused tick and the spare action make one frame division, a
// step makes one frame division plus the seek multiply, and a seek uses only the multiply.
// One transaction is in flight at a time: in_ready is high only while the sequencer is idle,
// and it stays low until the result has been taken; the sequencer returns to idle after each result.
// Reset clears the position to zero and loads the register defaults; no clearing pass.
// cfg_ready is always high; the user must write registers only while the block is idle (not enforced).
module playback_frame_timebase #(
    parameter int FRAME_INDEX_BITS       = 16,
    parameter int POSITION_FRACTION_BITS = 8
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // command channel
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic [pfb_pkg::ACTION_W-1:0]           action,
    input  wire logic [pfb_pkg::TIME_W-1:0]             elapsed_time,
    input  wire logic [pfb_pkg::COUNT_W-1:0]            target_frame,
    input  wire logic signed [pfb_pkg::COUNT_W-1:0]     step_frames,
    // result channel
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic [FRAME_INDEX_BITS-1:0]                 frame_index,
    output logic [pfb_pkg::POS_INT_W-1:0]               play_position,
    // register write channel
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [pfb_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [pfb_pkg::CFG_DATA_W-1:0]         cfg_data
);

    localparam int F   = POSITION_FRACTION_BITS;
    localparam int IW  = pfb_pkg::POS_INT_W;
    localparam int PW  = IW + F;              // position width
    localparam int XW  = PW + 2;              // signed wrap operand
    localparam int NW  = PW + 1;              // divider dividend width
    localparam int CW  = $clog2(NW + 1);
    localparam int MPW = pfb_pkg::MUL_P_W;
    localparam logic [CW-1:0] ITER_MOD = CW'(NW);
    localparam logic [CW-1:0] ITER_FRM = CW'(IW);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_SPD,    // elapsed * speed
        S_MUL_BASE,   // loop start * period, or clip length
        S_MUL_DUR,    // loop length
        S_MOD_START,
        S_MOD_WAIT,
        S_FRM_START,
        S_FRM_WAIT,
        S_SEEK_MUL,
        S_SEEK_WR,
        S_OUT
    } state_t;

    pfb_pkg::cfg_t cfg;

    state_t        state_reg, state_next;
    logic [PW-1:0] position_reg, position_next;

    // datapath registers
    logic [pfb_pkg::ACTION_W-1:0]        act_reg;
    logic [pfb_pkg::TIME_W-1:0]          elapsed_reg;
    logic signed [pfb_pkg::COUNT_W-1:0]  step_reg;
    logic [pfb_pkg::COUNT_W-1:0]         seek_frame_reg;
    logic signed [MPW-1:0]               mprod_reg;
    logic signed [XW-1:0]                sprod_reg;
    logic [IW-1:0]                       base_reg;
    logic [PW-1:0]                       start_shift_reg;
    logic [PW-1:0]                       d_reg;
    logic                                neg_reg;
    logic [FRAME_INDEX_BITS-1:0]         frame_out_reg;

    // multiplier
    logic [pfb_pkg::MUL_A_W-1:0]         mul_a;
    logic signed [pfb_pkg::MUL_B_W-1:0]  mul_b;
    logic signed [MPW-1:0]               mul_p;

    // divider
    logic          div_start;
    logic [NW-1:0] div_num;
    logic [PW-1:0] div_den;
    logic [CW-1:0] div_iters;
    logic          div_busy;
    logic          div_done;
    logic [NW-1:0] div_quo;
    logic [PW-1:0] div_rem;

    // combinational helpers
    logic signed [XW-1:0]         sp_ext;
    logic signed [XW-1:0]         sp_scaled;
    logic [PW-1:0]                loop_shift;
    logic [PW-1:0]                start_shift;
    logic signed [XW-1:0]         x_val;
    logic [NW-1:0]                x_mag;
    logic [PW-1:0]                mod_den;
    logic [PW-1:0]                wrapped;
    logic [IW-1:0]                quo_frame;
    logic signed [IW+1:0]         next_frame;
    logic [pfb_pkg::COUNT_W-1:0]  step_target;
    logic [pfb_pkg::COUNT_W-1:0]  seek_clamped;
    logic [IW-1:0]                seek_wide;
    logic                         loop_empty;

    logic in_fire;
    logic out_fire;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    pfb_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    pfb_div #(
        .NW (NW),
        .DW (PW),
        .CW (CW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .iters (div_iters),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    // Shared 24 x 17 signed multiplier; operands picked by the sequencer.
    always_comb
    begin
        mul_a = cfg.period;
        mul_b = '0;
        case (state_reg)
            S_MUL_SPD:
            begin
                mul_a = pfb_pkg::MUL_A_W'(elapsed_reg);
                mul_b = pfb_pkg::MUL_B_W'(cfg.speed);
            end
            S_MUL_BASE:
                mul_b = cfg.loop_en ? $signed({1'b0, cfg.loop_start}) : $signed({1'b0, cfg.count});
            S_MUL_DUR:
                mul_b = $signed({1'b0, cfg.loop_end - cfg.loop_start});
            S_SEEK_MUL:
                mul_b = $signed({1'b0, seek_clamped});
            default:
                mul_b = '0;
        endcase
    end

    assign mul_p = $signed({1'b0, mul_a}) * mul_b;

    // Speed product in position units: times 2^F, then floor divide by 2^8.
    assign sp_ext    = XW'(mprod_reg);
    assign sp_scaled = (sp_ext <<< F) >>> 8;

    // Wrap operand: position + increment - window start, wrapped by true modulo.
    assign loop_shift  = PW'(base_reg) << F;
    assign start_shift = cfg.loop_en ? loop_shift : '0;
    assign x_val       = $signed(XW'(position_reg)) + sprod_reg - $signed(XW'(start_shift));
    assign x_mag       = x_val[XW-1] ? NW'(-x_val) : NW'(x_val);
    assign mod_den     = PW'(mprod_reg[IW-1:0]) << F;
    assign wrapped     = (neg_reg && div_rem != '0) ? (d_reg - div_rem) : div_rem;
    assign loop_empty  = (cfg.loop_end <= cfg.loop_start);

    // Step: current frame plus signed count, floor at zero, ceiling at last frame.
    assign quo_frame  = div_quo[IW-1:0];
    assign next_frame = $signed({2'b00, quo_frame}) + (IW+2)'(step_reg);

    always_comb
    begin
        if (next_frame[IW+1])
            step_target = '0;
        else if (next_frame[IW:0] > (IW+1)'(cfg.last_frame))
            step_target = cfg.last_frame;
        else
            step_target = next_frame[pfb_pkg::COUNT_W-1:0];
    end

    // Seek clamp: end first, then start, so the start frame wins when inverted.
    always_comb
    begin
        seek_clamped = seek_frame_reg;
        if (cfg.loop_en)
        begin
            if (seek_clamped > cfg.loop_end)
                seek_clamped = cfg.loop_end;
            if (seek_clamped < cfg.loop_start)
                seek_clamped = cfg.loop_start;
        end
    end

    assign seek_wide = IW'(seek_clamped);

    // Divider requests
    always_comb
    begin
        div_start = 1'b0;
        div_num   = NW'(x_mag);
        div_den   = mod_den;
        div_iters = ITER_MOD;
        case (state_reg)
            S_MOD_START:
                div_start = 1'b1;
            S_FRM_START:
            begin
                div_start = 1'b1;
                div_num   = NW'(position_reg >> F) << (NW - IW);
                div_den   = PW'(cfg.period);
                div_iters = ITER_FRM;
            end
            default:
                div_start = 1'b0;
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        position_next = position_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    case (action)
                        pfb_pkg::ACT_TICK: state_next = cfg.paused ? S_FRM_START : S_MUL_SPD;
                        pfb_pkg::ACT_SEEK: state_next = S_SEEK_MUL;
                        pfb_pkg::ACT_STEP: state_next = S_FRM_START;
                        default:           state_next = S_FRM_START;
                    endcase
                end
            end
            S_MUL_SPD:
                state_next = S_MUL_BASE;
            S_MUL_BASE:
                state_next = cfg.loop_en ? S_MUL_DUR : S_MOD_START;
            S_MUL_DUR:
            begin
                // empty or inverted window holds at the loop start
                if (loop_empty)
                begin
                    position_next = PW'(mprod_reg[IW-1:0]) << F;
                    state_next    = S_FRM_START;
                end
                else
                    state_next = S_MOD_START;
            end
            S_MOD_START:
                state_next = S_MOD_WAIT;
            S_MOD_WAIT:
            begin
                if (div_done)
                begin
                    position_next = wrapped + start_shift_reg;
                    state_next    = S_FRM_START;
                end
            end
            S_FRM_START:
                state_next = S_FRM_WAIT;
            S_FRM_WAIT:
            begin
                if (div_done)
                    state_next = (act_reg == pfb_pkg::ACT_STEP) ? S_SEEK_MUL : S_OUT;
            end
            S_SEEK_MUL:
                state_next = S_SEEK_WR;
            S_SEEK_WR:
            begin
                position_next = PW'(mprod_reg[IW-1:0]) << F;
                state_next    = S_OUT;
            end
            S_OUT:
            begin
                if (out_fire)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            position_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            position_reg <= position_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mprod_reg <= mul_p;
        case (state_reg)
            S_IDLE:
            begin
                act_reg        <= action;
                elapsed_reg    <= elapsed_time;
                step_reg       <= step_frames;
                seek_frame_reg <= target_frame;
            end
            S_MUL_BASE:
                sprod_reg <= sp_scaled;
            S_MUL_DUR:
                base_reg <= mprod_reg[IW-1:0];
            S_MOD_START:
            begin
                neg_reg         <= x_val[XW-1];
                d_reg           <= mod_den;
                start_shift_reg <= start_shift;
            end
            S_FRM_WAIT:
            begin
                if (div_done)
                begin
                    frame_out_reg  <= quo_frame[FRAME_INDEX_BITS-1:0];
                    seek_frame_reg <= step_target;
                end
            end
            S_SEEK_MUL:
                frame_out_reg <= seek_wide[FRAME_INDEX_BITS-1:0];
            default:
                ;
        endcase
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = (state_reg == S_OUT);
    assign cfg_ready     = 1'b1;
    assign frame_index   = frame_out_reg;
    assign play_position = position_reg[PW-1:F];

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready)
        else $error("command accepted but sequencer still idle");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_MOD_WAIT || state_reg == S_FRM_WAIT))
        else $error("divider finished outside a wait state");

    a_start_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while running");

    a_ready_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire |=> (in_ready && !out_valid))
        else $error("result taken but not back to idle");

endmodule

`default_nettype wire

@@ hdl/pfb_regs.sv @@
`default_nettype none

module pfb_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             wr_en,
    input  wire logic [pfb_pkg::CFG_IDX_W-1:0]    wr_index,
    input  wire logic [pfb_pkg::CFG_DATA_W-1:0]   wr_data,
    output pfb_pkg::cfg_t                         cfg
);

    logic [pfb_pkg::PERIOD_W-1:0] period_reg;
    logic [pfb_pkg::COUNT_W-1:0]  count_reg;
    logic                         loop_en_reg;
    logic [pfb_pkg::COUNT_W-1:0]  loop_start_reg;
    logic [pfb_pkg::COUNT_W-1:0]  loop_end_reg;
    logic [pfb_pkg::SPEED_W-1:0]  speed_reg;
    logic                         paused_reg;

    logic [pfb_pkg::COUNT_W-1:0]  count_eff;
    logic [pfb_pkg::COUNT_W-1:0]  last_frame;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg     <= pfb_pkg::PERIOD_RST;
            count_reg      <= pfb_pkg::COUNT_RST;
            loop_en_reg    <= 1'b0;
            loop_start_reg <= '0;
            loop_end_reg   <= '0;
            speed_reg      <= pfb_pkg::SPEED_RST;
            paused_reg     <= 1'b0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                pfb_pkg::REG_FRAME_PERIOD: period_reg     <= wr_data;
                pfb_pkg::REG_FRAME_COUNT:  count_reg      <= wr_data[pfb_pkg::COUNT_W-1:0];
                pfb_pkg::REG_LOOP_ENABLE:  loop_en_reg    <= wr_data[0];
                pfb_pkg::REG_LOOP_START:   loop_start_reg <= wr_data[pfb_pkg::COUNT_W-1:0];
                pfb_pkg::REG_LOOP_END:     loop_end_reg   <= wr_data[pfb_pkg::COUNT_W-1:0];
                pfb_pkg::REG_SPEED:        speed_reg      <= wr_data[pfb_pkg::SPEED_W-1:0];
                pfb_pkg::REG_PAUSED:       paused_reg     <= wr_data[0];
                default:                   ;
            endcase
        end
    end

    assign count_eff  = (count_reg == '0) ? pfb_pkg::COUNT_W'(1) : count_reg;
    assign last_frame = count_eff - pfb_pkg::COUNT_W'(1);

    always_comb
    begin
        cfg.period     = (period_reg == '0) ? pfb_pkg::PERIOD_W'(1) : period_reg;
        cfg.count      = count_eff;
        cfg.last_frame = last_frame;
        cfg.loop_en    = loop_en_reg;
        cfg.loop_start = (loop_start_reg > last_frame) ? last_frame : loop_start_reg;
        cfg.loop_end   = (loop_end_reg > last_frame) ? last_frame : loop_end_reg;
        cfg.speed      = $signed(speed_reg);
        cfg.paused     = paused_reg;
    end

endmodule

`default_nettype wire

@@ hdl/pfb_div.sv @@
`default_nettype none

// Restoring divider, one quotient bit per cycle.
// The dividend is taken from its top bit down for 'iters' steps; a short
// dividend is passed left-aligned.
module pfb_div #(
    parameter int NW = 49,
    parameter int DW = 48,
    parameter int CW = $clog2(NW + 1)
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    input  wire logic [CW-1:0] iters,
    output logic               busy,
    output logic               done,
    output logic [NW-1:0]      quo,
    output logic [DW-1:0]      rem
);

    logic [NW-1:0] num_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [DW:0]   trial;
    logic          fits;

    assign trial = {rem_reg, num_reg[NW-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= iters;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NW-2:0], fits};
            rem_reg <= fits ? DW'(trial - {1'b0, den_reg}) : trial[DW-1:0];
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = num_reg;
    assign rem  = rem_reg;

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !start && den_reg != '0) |-> (rem_reg < den_reg))
        else $error("divider remainder not below divisor");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(busy_reg) && !busy_reg))
        else $error("divider done without a run");

    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (start && iters != '0) |=> busy_reg)
        else $error("divider did not start");

endmodule

`default_nettype wire

@@ dv/timebase_check.sv @@
`timescale 1ns / 1ps

module timebase_check (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic [pfb_pkg::ACTION_W-1:0]        action,
    input  logic [pfb_pkg::TIME_W-1:0]          elapsed_time,
    input  logic [pfb_pkg::COUNT_W-1:0]         target_frame,
    input  logic signed [pfb_pkg::COUNT_W-1:0]  step_frames,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [15:0]                         frame_index,
    input  logic [pfb_pkg::POS_INT_W-1:0]       play_position,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [pfb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pfb_pkg::CFG_DATA_W-1:0]      cfg_data,
    output int                                  fail_count,
    output int                                  results_seen,
    output int                                  backlog
);

    localparam int FRAME_BITS = 16;
    localparam int FRAC       = 8;
    localparam int POS_W      = pfb_pkg::POS_INT_W + FRAC;

    typedef struct packed {
        logic [FRAME_BITS-1:0]         frame;
        logic [pfb_pkg::POS_INT_W-1:0] whole;
    } frame_pos_t;

    logic [pfb_pkg::PERIOD_W-1:0]       period;
    logic [pfb_pkg::COUNT_W-1:0]        clip_len;
    logic                               loop_on;
    logic [pfb_pkg::COUNT_W-1:0]        loop_first;
    logic [pfb_pkg::COUNT_W-1:0]        loop_last;
    logic signed [pfb_pkg::SPEED_W-1:0] speed;
    logic                               frozen;
    logic [POS_W-1:0]                   pos;

    frame_pos_t due_q[$];
    frame_pos_t want;

    function automatic longint per_eff();
        return (period == 0) ? 64'sd1 : longint'(period);
    endfunction

    function automatic longint len_eff();
        return (clip_len == 0) ? 64'sd1 : longint'(clip_len);
    endfunction

    function automatic longint clip_frame(input longint f);
        longint last;
        last = len_eff() - 1;
        return (f > last) ? last : f;
    endfunction

    function automatic longint frame_now();
        return longint'(pos >> FRAC) / per_eff();
    endfunction

    // floored modulo, result always in [0, d)
    function automatic longint wrap(input longint x, input longint d);
        longint m;
        m = x % d;
        if (m < 0)
        begin
            m = m + d;
        end
        return m;
    endfunction

    // start frame wins over end frame when the window is inverted
    function automatic void seek_frame(input longint f);
        longint lo;
        longint hi;
        if (loop_on)
        begin
            lo = clip_frame(longint'(loop_first));
            hi = clip_frame(longint'(loop_last));
            if (f > hi)
            begin
                f = hi;
            end
            if (f < lo)
            begin
                f = lo;
            end
        end
        pos = POS_W'((f * per_eff()) << FRAC);
    endfunction

    function automatic void advance(input longint et);
        longint per;
        longint delta;
        longint p;
        longint lo;
        longint hi;
        longint base;
        if (frozen)
        begin
            return;
        end
        per   = per_eff();
        delta = et * longint'(speed);
        // Q8.8 speed against FRAC position bits; floor when fewer than 8
        if (FRAC >= 8)
        begin
            delta = delta <<< (FRAC - 8);
        end
        else
        begin
            delta = delta >>> (8 - FRAC);
        end
        p = longint'(pos) + delta;
        if (loop_on)
        begin
            lo   = clip_frame(longint'(loop_first));
            hi   = clip_frame(longint'(loop_last));
            base = (lo * per) << FRAC;
            if (hi <= lo)
            begin
                p = base;   // empty window: park at its start
            end
            else
            begin
                p = wrap(p - base, ((hi - lo) * per) << FRAC) + base;
            end
        end
        else
        begin
            p = wrap(p, (len_eff() * per) << FRAC);
        end
        pos = POS_W'(p);
    endfunction

    function automatic void step_frames_by(input longint inc);
        longint nf;
        nf = frame_now() + inc;
        if (nf < 0)
        begin
            seek_frame(0);
        end
        else
        begin
            seek_frame(clip_frame(nf));
        end
    endfunction

    function automatic frame_pos_t report_now();
        longint f;
        frame_pos_t r;
        f       = frame_now();
        r.frame = f[FRAME_BITS-1:0];
        r.whole = pos[POS_W-1:FRAC];
        return r;
    endfunction

    task automatic flag(input string msg);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("%0t mismatch: %s", $time, msg);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period       = pfb_pkg::PERIOD_RST;
            clip_len     = pfb_pkg::COUNT_RST;
            loop_on      = 1'b0;
            loop_first   = '0;
            loop_last    = '0;
            speed        = pfb_pkg::SPEED_RST;
            frozen       = 1'b0;
            pos          = '0;
            due_q.delete();
            fail_count   = 0;
            results_seen = 0;
            backlog      = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (due_q.size() == 0)
                begin
                    flag($sformatf("result %0d/%0d with nothing pending",
                                   frame_index, play_position));
                end
                else
                begin
                    want = due_q.pop_front();
                    if (frame_index !== want.frame)
                    begin
                        flag($sformatf("frame_index expected %0d got %0d",
                                       want.frame, frame_index));
                    end
                    if (play_position !== want.whole)
                    begin
                        flag($sformatf("play_position expected %0d got %0d",
                                       want.whole, play_position));
                    end
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    pfb_pkg::REG_FRAME_PERIOD:
                        period     = cfg_data[pfb_pkg::PERIOD_W-1:0];
                    pfb_pkg::REG_FRAME_COUNT:
                        clip_len   = cfg_data[pfb_pkg::COUNT_W-1:0];
                    pfb_pkg::REG_LOOP_ENABLE:
                        loop_on    = cfg_data[0];
                    pfb_pkg::REG_LOOP_START:
                        loop_first = cfg_data[pfb_pkg::COUNT_W-1:0];
                    pfb_pkg::REG_LOOP_END:
                        loop_last  = cfg_data[pfb_pkg::COUNT_W-1:0];
                    pfb_pkg::REG_SPEED:
                        speed      = cfg_data[pfb_pkg::SPEED_W-1:0];
                    pfb_pkg::REG_PAUSED:
                        frozen     = cfg_data[0];
                    default: ;
                endcase
            end

            if (in_valid && in_ready)
            begin
                case (action)
                    pfb_pkg::ACT_TICK: advance(longint'(elapsed_time));
                    pfb_pkg::ACT_SEEK: seek_frame(longint'(target_frame));
                    pfb_pkg::ACT_STEP: step_frames_by(longint'(step_frames));
                    default: ;
                endcase
                due_q.insert(due_q.size(), report_now());
            end

            backlog = due_q.size();
        end
    end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

// Stimulus and verdict for playback_frame_timebase. All prediction and comparison
// happens in timebase_check, which watches the three channels from the outside.
module tb;

    localparam int TOTAL_ITEMS = 1900;
    localparam int QUIET_FROM  = 1650;  // no idling on either side past this point
    localparam int IDLE_LIMIT  = 2000;  // must cover the slowest tick plus gaps/stalls
    localparam int TAIL_CYCLES = 120;

    // codes the package does not name: spare action and spare register slot
    localparam logic [pfb_pkg::ACTION_W-1:0]  ACT_UNUSED = 2'd3;
    localparam logic [pfb_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct {
        logic [pfb_pkg::PERIOD_W-1:0] period;
        logic [pfb_pkg::COUNT_W-1:0]  count;
        logic                         loop_en;
        logic [pfb_pkg::COUNT_W-1:0]  loop_start;
        logic [pfb_pkg::COUNT_W-1:0]  loop_end;
        logic [pfb_pkg::SPEED_W-1:0]  speed;
        logic                         paused;
    } timebase_cfg_t;

    logic                               clk           = 1'b0;
    logic                               rst_n         = 1'b0;
    logic                               in_valid      = 1'b0;
    logic                               in_ready;
    logic [pfb_pkg::ACTION_W-1:0]       action        = pfb_pkg::ACT_TICK;
    logic [pfb_pkg::TIME_W-1:0]         elapsed_time  = '0;
    logic [pfb_pkg::COUNT_W-1:0]        target_frame  = '0;
    logic signed [pfb_pkg::COUNT_W-1:0] step_frames   = '0;
    logic                               out_valid;
    logic                               out_ready     = 1'b0;
    logic [15:0]                        frame_index;
    logic [pfb_pkg::POS_INT_W-1:0]      play_position;
    logic                               cfg_valid     = 1'b0;
    logic                               cfg_ready;
    logic [pfb_pkg::CFG_IDX_W-1:0]      cfg_index     = pfb_pkg::REG_FRAME_PERIOD;
    logic [pfb_pkg::CFG_DATA_W-1:0]     cfg_data      = '0;

    int            fail_count;
    int            results_seen;
    int            backlog;
    int            sent        = 0;
    logic          quiet       = 1'b0;
    int            ready_left  = 0;
    int            idle_cycles = 0;
    timebase_cfg_t cfg_now;

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    playback_frame_timebase uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .elapsed_time  (elapsed_time),
        .target_frame  (target_frame),
        .step_frames   (step_frames),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .frame_index   (frame_index),
        .play_position (play_position),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    timebase_check u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .elapsed_time  (elapsed_time),
        .target_frame  (target_frame),
        .step_frames   (step_frames),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .frame_index   (frame_index),
        .play_position (play_position),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .results_seen  (results_seen),
        .backlog       (backlog)
    );

    // Result-side backpressure: ready is held high or dropped at random, and
    // every drop is always followed by ready again.
    // Always ready once the quiet tail starts.
    always @(posedge clk)
    begin
        if (quiet)
        begin
            out_ready  <= 1'b1;
            ready_left <= 0;
        end
        else if (ready_left != 0)
        begin
            ready_left <= ready_left - 1;
        end
        else if (out_ready && $urandom_range(0, 3) == 0)
        begin
            out_ready  <= 1'b0;
            ready_left <= $urandom_range(0, 11);
        end
        else
        begin
            out_ready  <= 1'b1;
            ready_left <= $urandom_range(0, 19);
        end
    end

    // Watchdog: any transaction on any channel restarts the count.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("FAIL playback_frame_timebase");
            $finish;
        end
    end

    function automatic timebase_cfg_t make_cfg(input logic [pfb_pkg::PERIOD_W-1:0] per,
                                               input logic [pfb_pkg::COUNT_W-1:0] cnt,
                                               input logic lp,
                                               input logic [pfb_pkg::COUNT_W-1:0] first,
                                               input logic [pfb_pkg::COUNT_W-1:0] last,
                                               input logic [pfb_pkg::SPEED_W-1:0] spd,
                                               input logic hold);
        timebase_cfg_t c;
        c.period     = per;
        c.count      = cnt;
        c.loop_en    = lp;
        c.loop_start = first;
        c.loop_end   = last;
        c.speed      = spd;
        c.paused     = hold;
        return c;
    endfunction

    // Narrow registers sometimes get junk above their width; it must be ignored.
    function automatic logic [pfb_pkg::CFG_DATA_W-1:0] pad(
        input logic [pfb_pkg::CFG_DATA_W-1:0] v,
        input int w);
        logic [pfb_pkg::CFG_DATA_W-1:0] junk;
        junk = pfb_pkg::CFG_DATA_W'($urandom);
        if (w < pfb_pkg::CFG_DATA_W && $urandom_range(0, 3) == 0)
        begin
            v = v | (junk << w);
        end
        return v;
    endfunction

    // Call right after the clock rises; leaves cfg_valid high on return.
    task automatic write_reg(input logic [pfb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pfb_pkg::CFG_DATA_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Only called with the block idle (after reset or after drain).
    task automatic set_config(input timebase_cfg_t c);
        write_reg(pfb_pkg::REG_FRAME_PERIOD, c.period);
        write_reg(pfb_pkg::REG_FRAME_COUNT,
                  pad(pfb_pkg::CFG_DATA_W'(c.count), pfb_pkg::COUNT_W));
        write_reg(pfb_pkg::REG_LOOP_ENABLE, pad(pfb_pkg::CFG_DATA_W'(c.loop_en), 1));
        write_reg(pfb_pkg::REG_LOOP_START,
                  pad(pfb_pkg::CFG_DATA_W'(c.loop_start), pfb_pkg::COUNT_W));
        write_reg(pfb_pkg::REG_LOOP_END,
                  pad(pfb_pkg::CFG_DATA_W'(c.loop_end), pfb_pkg::COUNT_W));
        write_reg(pfb_pkg::REG_SPEED,
                  pad(pfb_pkg::CFG_DATA_W'(c.speed), pfb_pkg::SPEED_W));
        write_reg(pfb_pkg::REG_PAUSED, pad(pfb_pkg::CFG_DATA_W'(c.paused), 1));
        if ($urandom_range(0, 5) == 0)
        begin
            write_reg(REG_UNUSED, pfb_pkg::CFG_DATA_W'($urandom));  // no register there
        end
        cfg_valid <= 1'b0;
        cfg_now = c;
    endtask

    // One command transaction, optionally preceded by an idle burst.
    // Returns in the step of acceptance with in_valid still high.
    task automatic send_cmd(input logic [pfb_pkg::ACTION_W-1:0] act,
                            input logic [pfb_pkg::TIME_W-1:0] et,
                            input logic [pfb_pkg::COUNT_W-1:0] tf,
                            input logic signed [pfb_pkg::COUNT_W-1:0] sf);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 12);
        end
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        action       <= act;
        elapsed_time <= et;
        target_frame <= tf;
        step_frames  <= sf;
        do @(posedge clk); while (!in_ready);
        sent++;
    endtask

    // Wait until every command has its result back, then let the block settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (results_seen < sent) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Mostly short clips and periods so that frames, wraps and clamps get hit often.
    function automatic timebase_cfg_t random_config();
        timebase_cfg_t c;
        int lc;
        case ($urandom_range(0, 9))
            0:       c.period = '0;
            1:       c.period = '1;
            2:       c.period = pfb_pkg::PERIOD_RST;
            3, 4, 5: c.period = pfb_pkg::PERIOD_W'($urandom_range(1, 16));
            6, 7:    c.period = pfb_pkg::PERIOD_W'($urandom_range(17, 5000));
            default: c.period = pfb_pkg::PERIOD_W'($urandom);
        endcase
        case ($urandom_range(0, 7))
            0:       c.count = '0;
            1:       c.count = 16'd1;
            2:       c.count = '1;
            3, 4, 5: c.count = pfb_pkg::COUNT_W'($urandom_range(2, 40));
            default: c.count = pfb_pkg::COUNT_W'($urandom_range(41, 3000));
        endcase
        lc = (c.count == 0) ? 1 : int'(c.count);
        c.loop_en    = 1'($urandom_range(0, 1));
        // one past the last frame is allowed so the clamp gets exercised
        c.loop_start = ($urandom_range(0, 5) == 0) ? pfb_pkg::COUNT_W'($urandom)
                                                   : pfb_pkg::COUNT_W'($urandom_range(0, lc));
        c.loop_end   = ($urandom_range(0, 5) == 0) ? pfb_pkg::COUNT_W'($urandom)
                                                   : pfb_pkg::COUNT_W'($urandom_range(0, lc));
        case ($urandom_range(0, 8))
            0:       c.speed = 16'sd256;
            1:       c.speed = -16'sd256;
            2:       c.speed = 16'sh7FFF;
            3:       c.speed = 16'sh8000;
            4:       c.speed = '0;
            5, 6:    c.speed = pfb_pkg::SPEED_W'(int'($urandom_range(0, 4096)) - 2048);
            default: c.speed = pfb_pkg::SPEED_W'($urandom);
        endcase
        c.paused = ($urandom_range(0, 7) == 0);
        return c;
    endfunction

    // Every field is randomized on every command, used or not.
    task automatic random_item();
        int pick;
        int lim;
        logic [pfb_pkg::ACTION_W-1:0]       act;
        logic [pfb_pkg::TIME_W-1:0]         et;
        logic [pfb_pkg::COUNT_W-1:0]        tf;
        logic signed [pfb_pkg::COUNT_W-1:0] sf;
        lim  = (cfg_now.count == 0) ? 1 : int'(cfg_now.count);
        pick = $urandom_range(0, 99);
        if (pick < 50)
        begin
            act = pfb_pkg::ACT_TICK;
        end
        else if (pick < 70)
        begin
            act = pfb_pkg::ACT_SEEK;
        end
        else if (pick < 95)
        begin
            act = pfb_pkg::ACT_STEP;
        end
        else
        begin
            act = ACT_UNUSED;
        end
        case ($urandom_range(0, 2))
            0:       et = pfb_pkg::TIME_W'($urandom);
            1:       et = pfb_pkg::TIME_W'($urandom_range(0, 300));
            default: et = pfb_pkg::TIME_W'($urandom_range(0, 3));
        endcase
        tf = ($urandom_range(0, 2) == 0) ? pfb_pkg::COUNT_W'($urandom)
                                         : pfb_pkg::COUNT_W'($urandom_range(0, lim + 1));
        case ($urandom_range(0, 3))
            0:       sf = pfb_pkg::COUNT_W'(int'($urandom_range(0, 8)) - 4);
            1:       sf = pfb_pkg::COUNT_W'(int'($urandom_range(0, 2 * lim)) - lim);
            default: sf = pfb_pkg::COUNT_W'($urandom);
        endcase
        send_cmd(act, et, tf, sf);
    endtask

    initial
    begin
        timebase_cfg_t c;
        int n;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        cfg_now = make_cfg(pfb_pkg::PERIOD_RST, pfb_pkg::COUNT_RST, 1'b0, '0, '0,
                           pfb_pkg::SPEED_RST, 1'b0);

        // --- directed ---
        // Reset defaults: one-frame clip. Full-scale tick wraps over the clip,
        // spare action reports unchanged state, seek past the clip is not clamped
        // without looping, steps hit both ends.
        send_cmd(pfb_pkg::ACT_TICK, 16'hFFFF, '0, '0);
        send_cmd(pfb_pkg::ACT_TICK, '0,       '0, '0);
        send_cmd(ACT_UNUSED,        16'hFFFF, 16'hFFFF, 16'sh7FFF);
        send_cmd(pfb_pkg::ACT_SEEK, '0,       16'hFFFF, '0);
        send_cmd(pfb_pkg::ACT_TICK, 16'd1,    '0, '0);
        send_cmd(pfb_pkg::ACT_STEP, '0,       '0, 16'sh8000);
        send_cmd(pfb_pkg::ACT_STEP, '0,       '0, 16'sh7FFF);
        drain();

        // Zero period and zero count read as one; most negative speed wraps upward.
        set_config(make_cfg('0, '0, 1'b0, '0, '0, 16'sh8000, 1'b0));
        send_cmd(pfb_pkg::ACT_TICK, 16'hFFFF, '0, '0);
        send_cmd(pfb_pkg::ACT_STEP, '0, '0, 16'sd5);
        send_cmd(pfb_pkg::ACT_SEEK, '0, 16'd7, '0);
        drain();

        // Loop window 20..30 of a 100-frame clip at full forward speed.
        set_config(make_cfg(24'd10, 16'd100, 1'b1, 16'd20, 16'd30, 16'sh7FFF, 1'b0));
        send_cmd(pfb_pkg::ACT_TICK, 16'hFFFF, '0, '0);
        send_cmd(pfb_pkg::ACT_SEEK, '0, 16'd5, '0);
        send_cmd(pfb_pkg::ACT_SEEK, '0, 16'd99, '0);
        send_cmd(pfb_pkg::ACT_STEP, '0, '0, 16'sh8000);
        send_cmd(pfb_pkg::ACT_STEP, '0, '0, 16'sh7FFF);
        send_cmd(pfb_pkg::ACT_STEP, '0, '0, -16'sd3);
        drain();

        // Inverted window: tick parks at the start frame, seek clamp lets start win.
        c = make_cfg(24'd10, 16'd100, 1'b1, 16'd50, 16'd10, -16'sd256, 1'b0);
        set_config(c);
        send_cmd(pfb_pkg::ACT_TICK, 16'd300, '0, '0);
        send_cmd(pfb_pkg::ACT_SEEK, '0, 16'd30, '0);
        drain();
        // both bounds past the clip clamp to the same last frame: empty window
        c.loop_start = 16'd200;
        c.loop_end   = 16'hFFFF;
        set_config(c);
        send_cmd(pfb_pkg::ACT_TICK, 16'd5, '0, '0);
        send_cmd(pfb_pkg::ACT_SEEK, '0, '0, '0);
        drain();

        // Largest period and clip: paused tick, seek one past the last frame, step back one, then run.
        c = make_cfg('1, '1, 1'b0, '0, '1, 16'sh7FFF, 1'b1);
        set_config(c);
        send_cmd(pfb_pkg::ACT_TICK, 16'hFFFF, '0, '0);
        send_cmd(pfb_pkg::ACT_SEEK, '0, 16'hFFFF, '0);
        send_cmd(pfb_pkg::ACT_STEP, '0, '0, -16'sd1);
        drain();
        c.paused = 1'b0;
        set_config(c);
        send_cmd(pfb_pkg::ACT_TICK, 16'hFFFF, '0, '0);
        drain();

        // --- random phases: new settings, a batch of commands, drain ---
        while (sent < TOTAL_ITEMS)
        begin
            if (sent >= QUIET_FROM)
            begin
                quiet <= 1'b1;
            end
            set_config(random_config());
            n = $urandom_range(8, 60);
            repeat (n) random_item();
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0 && backlog == 0)
        begin
            $display("PASS playback_frame_timebase");
        end
        else
        begin
            $display("FAIL playback_frame_timebase");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/pfb_pkg.sv
hdl/pfb_regs.sv
hdl/pfb_div.sv
hdl/playback_frame_timebase.sv
dv/timebase_check.sv
dv/tb.sv
